// File: rtl/mm_pkg.sv
// Package with sizes, codes, types and helpers shared by the matrix multiply block.
package mm_pkg;

    localparam int MAX_DIM = 8;
    localparam int DIM_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W   = $clog2(MAX_DIM + 1);
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int OP_W    = 2;
    localparam int IDX_W   = 3;
    localparam int ELEM_W  = 16;
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int SUM_W   = 40;
    localparam int CFG_W   = 4;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_COMPUTE = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS_A    = 2'd0,
        REG_INNER_DIM = 2'd1,
        REG_COLS_B    = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic              we_a;
        logic              we_b;
        logic [ADDR_W-1:0] addr;
        logic [ELEM_W-1:0] data;
    } store_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] a_addr;
        logic [ADDR_W-1:0] b_addr;
    } store_rd_t;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             fin;
        logic             zero;
        logic             last;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
    } step_t;

    function automatic logic [CNT_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
        logic [CNT_W-1:0] r;
        if (int'(d) > MAX_DIM)
        begin
            r = CNT_W'(MAX_DIM);
        end
        else
        begin
            r = CNT_W'(d);
        end
        return r;
    endfunction

endpackage

// File: rtl/mm_if.sv
// Valid/ready channel interfaces for input words, result words and register writes.
interface mm_in_if;
    logic                              valid;
    logic                              ready;
    logic [mm_pkg::OP_W-1:0]           operation;
    logic [mm_pkg::IDX_W-1:0]          row_index;
    logic [mm_pkg::IDX_W-1:0]          col_index;
    logic signed [mm_pkg::ELEM_W-1:0]  element_value;

    modport source (output valid, operation, row_index, col_index, element_value,
                    input ready);
    modport sink   (input valid, operation, row_index, col_index, element_value,
                    output ready);
endinterface

interface mm_out_if;
    logic                              valid;
    logic                              ready;
    logic [mm_pkg::IDX_W-1:0]          out_row;
    logic [mm_pkg::IDX_W-1:0]          out_col;
    logic signed [mm_pkg::SUM_W-1:0]   product_value;
    logic                              last;

    modport source (output valid, out_row, out_col, product_value, last, input ready);
    modport sink   (input valid, out_row, out_col, product_value, last, output ready);
endinterface

interface mm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [mm_pkg::CFG_IDX_W-1:0]      index;
    logic [mm_pkg::CFG_W-1:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/mm_store.sv
// Element memories for A and B with one write port and a registered read port each.
module mm_store (
    input  logic                      clk,
    input  mm_pkg::store_wr_t         wr,
    input  mm_pkg::store_rd_t         rd,
    output logic [mm_pkg::ELEM_W-1:0] a_data,
    output logic [mm_pkg::ELEM_W-1:0] b_data
);

    logic [mm_pkg::ELEM_W-1:0] a_mem [mm_pkg::DEPTH];
    logic [mm_pkg::ELEM_W-1:0] b_mem [mm_pkg::DEPTH];
    logic [mm_pkg::ELEM_W-1:0] a_data_reg;
    logic [mm_pkg::ELEM_W-1:0] b_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we_a)
        begin
            a_mem[wr.addr] <= wr.data;
        end
        if (wr.we_b)
        begin
            b_mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            a_data_reg <= a_mem[rd.a_addr];
            b_data_reg <= b_mem[rd.b_addr];
        end
    end

    assign a_data = a_data_reg;
    assign b_data = b_data_reg;

endmodule

// File: rtl/mm_seq.sv
// Sequencer: register file, store writes and the row, column and inner index walk.
module mm_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    mm_in_if.sink                item,
    mm_cfg_if.sink               cfg,
    input  logic                 adv,
    input  logic                 done,
    output mm_pkg::store_wr_t    wr,
    output mm_pkg::store_rd_t    rd,
    output mm_pkg::step_t        step
);

    logic [mm_pkg::CFG_W-1:0] rows_a_reg;
    logic [mm_pkg::CFG_W-1:0] inner_dim_reg;
    logic [mm_pkg::CFG_W-1:0] cols_b_reg;
    logic                     busy_reg;
    logic                     active_reg;
    logic [mm_pkg::DIM_W-1:0] i_reg;
    logic [mm_pkg::DIM_W-1:0] j_reg;
    logic [mm_pkg::DIM_W-1:0] k_reg;

    logic [mm_pkg::CNT_W-1:0] nr;
    logic [mm_pkg::CNT_W-1:0] nk;
    logic [mm_pkg::CNT_W-1:0] nc;
    logic                     accept;
    logic                     start;
    logic                     issue;
    logic                     in_range;
    logic                     i_last;
    logic                     j_last;
    logic                     k_last;

    assign nr = mm_pkg::clamp_dim(rows_a_reg);
    assign nk = mm_pkg::clamp_dim(inner_dim_reg);
    assign nc = mm_pkg::clamp_dim(cols_b_reg);

    assign item.ready = !busy_reg;
    assign cfg.ready  = 1'b1;
    assign accept     = item.valid && item.ready;
    assign start      = accept && (item.operation == mm_pkg::OP_COMPUTE)
                        && (nr != '0) && (nc != '0);
    assign issue      = active_reg && adv;

    assign in_range = (int'(item.row_index) < mm_pkg::MAX_DIM)
                      && (int'(item.col_index) < mm_pkg::MAX_DIM);

    always_comb
    begin
        wr.we_a = 1'b0;
        wr.we_b = 1'b0;
        wr.addr = mm_pkg::ADDR_W'(mm_pkg::ADDR_W'(item.row_index)
                  * mm_pkg::ADDR_W'(mm_pkg::MAX_DIM) + mm_pkg::ADDR_W'(item.col_index));
        wr.data = item.element_value;
        unique case (item.operation)
            mm_pkg::OP_WRITE_A: wr.we_a = accept && in_range;
            mm_pkg::OP_WRITE_B: wr.we_b = accept && in_range;
            default:
            begin
                wr.we_a = 1'b0;
                wr.we_b = 1'b0;
            end
        endcase
    end

    assign k_last = (nk == '0) || (mm_pkg::CNT_W'(k_reg) == nk - mm_pkg::CNT_W'(1));
    assign j_last = (mm_pkg::CNT_W'(j_reg) == nc - mm_pkg::CNT_W'(1));
    assign i_last = (mm_pkg::CNT_W'(i_reg) == nr - mm_pkg::CNT_W'(1));

    assign rd.en     = issue;
    assign rd.a_addr = mm_pkg::ADDR_W'(mm_pkg::ADDR_W'(i_reg)
                       * mm_pkg::ADDR_W'(mm_pkg::MAX_DIM) + mm_pkg::ADDR_W'(k_reg));
    assign rd.b_addr = mm_pkg::ADDR_W'(mm_pkg::ADDR_W'(k_reg)
                       * mm_pkg::ADDR_W'(mm_pkg::MAX_DIM) + mm_pkg::ADDR_W'(j_reg));

    assign step.valid = issue;
    assign step.first = (k_reg == '0);
    assign step.fin   = k_last;
    assign step.zero  = (nk == '0);
    assign step.last  = i_last && j_last;
    assign step.row   = i_reg;
    assign step.col   = j_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= mm_pkg::CFG_W'(mm_pkg::MAX_DIM);
            inner_dim_reg <= mm_pkg::CFG_W'(mm_pkg::MAX_DIM);
            cols_b_reg    <= mm_pkg::CFG_W'(mm_pkg::MAX_DIM);
            busy_reg      <= 1'b0;
            active_reg    <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    mm_pkg::REG_ROWS_A:    rows_a_reg    <= cfg.data;
                    mm_pkg::REG_INNER_DIM: inner_dim_reg <= cfg.data;
                    mm_pkg::REG_COLS_B:    cols_b_reg    <= cfg.data;
                    default:               rows_a_reg    <= rows_a_reg;
                endcase
            end
            if (start)
            begin
                busy_reg   <= 1'b1;
                active_reg <= 1'b1;
                i_reg      <= '0;
                j_reg      <= '0;
                k_reg      <= '0;
            end
            else if (issue)
            begin
                if (!k_last)
                begin
                    k_reg <= k_reg + mm_pkg::DIM_W'(1);
                end
                else
                begin
                    k_reg <= '0;
                    if (!j_last)
                    begin
                        j_reg <= j_reg + mm_pkg::DIM_W'(1);
                    end
                    else
                    begin
                        j_reg <= '0;
                        if (!i_last)
                        begin
                            i_reg <= i_reg + mm_pkg::DIM_W'(1);
                        end
                        else
                        begin
                            active_reg <= 1'b0;
                        end
                    end
                end
            end
            if (done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/mm_mac.sv
// Multiply-accumulate pipeline behind the store read port, with the result output register.
module mm_mac (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mm_pkg::step_t             step,
    input  logic [mm_pkg::ELEM_W-1:0] a_data,
    input  logic [mm_pkg::ELEM_W-1:0] b_data,
    mm_out_if.source                  result,
    output logic                      adv,
    output logic                      done
);

    mm_pkg::step_t                    step1_reg;
    mm_pkg::step_t                    step2_reg;
    logic signed [mm_pkg::PROD_W-1:0] prod_reg;
    logic signed [mm_pkg::SUM_W-1:0]  acc_reg;
    logic                             out_valid_reg;
    logic [mm_pkg::IDX_W-1:0]         out_row_reg;
    logic [mm_pkg::IDX_W-1:0]         out_col_reg;
    logic signed [mm_pkg::SUM_W-1:0]  out_value_reg;
    logic                             out_last_reg;

    logic signed [mm_pkg::PROD_W-1:0] mult;
    logic signed [mm_pkg::PROD_W-1:0] prod_next;
    logic signed [mm_pkg::SUM_W-1:0]  acc_next;

    assign adv  = !out_valid_reg || result.ready;
    assign done = result.valid && result.ready && result.last;

    assign mult      = $signed(a_data) * $signed(b_data);
    assign prod_next = step1_reg.zero ? '0 : mult;
    assign acc_next  = (step2_reg.first ? '0 : acc_reg) + mm_pkg::SUM_W'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step1_reg     <= '0;
            step2_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            step1_reg     <= step;
            step2_reg     <= step1_reg;
            out_valid_reg <= step2_reg.valid && step2_reg.fin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            if (step2_reg.valid)
            begin
                acc_reg <= acc_next;
            end
            if (step2_reg.valid && step2_reg.fin)
            begin
                out_row_reg   <= mm_pkg::IDX_W'(step2_reg.row);
                out_col_reg   <= mm_pkg::IDX_W'(step2_reg.col);
                out_value_reg <= acc_next;
                out_last_reg  <= step2_reg.last;
            end
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.out_row       = out_row_reg;
    assign result.out_col       = out_col_reg;
    assign result.product_value = out_value_reg;
    assign result.last          = out_last_reg;

endmodule

// File: rtl/matrix_multiply.sv
// Top level of the matrix multiply block: sequencer, element memories and MAC pipeline.
//
// Usage: registers rows_a (index 0), inner_dim (1) and cols_b (2) are written on the cfg
// channel, which is always ready; write them only while the block is idle. Input words on
// the item channel either store one Q8.8 element of A or B at its row and column, or
// start a compute if rows_a and cols_b are nonzero; other operation codes are ignored.
// A compute emits every element of C in row-major order on the result channel as a
// Q24.16 sum, with last set on the final word. The elements of C are computed one after
// another on the single read port of the element memories; an inner_dim of zero gives
// elements of zero. A dimension register above eight counts as eight.
// While a compute runs, item.ready is low until the last result word has been taken.
// When the receiver stalls, the result register holds its word and the whole MAC pipeline
// and memory read port freeze until it is taken. Reset clears the control state and sets
// all three dimension registers to eight; the memory contents are undefined until written.
module matrix_multiply (
    input  logic      clk,
    input  logic      rst_n,
    mm_in_if.sink     item,
    mm_cfg_if.sink    cfg,
    mm_out_if.source  result
);

    mm_pkg::store_wr_t          wr;
    mm_pkg::store_rd_t          rd;
    mm_pkg::step_t              step;
    logic [mm_pkg::ELEM_W-1:0]  a_data;
    logic [mm_pkg::ELEM_W-1:0]  b_data;
    logic                       adv;
    logic                       done;

    mm_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .cfg   (cfg),
        .adv   (adv),
        .done  (done),
        .wr    (wr),
        .rd    (rd),
        .step  (step)
    );

    mm_store u_store (
        .clk    (clk),
        .wr     (wr),
        .rd     (rd),
        .a_data (a_data),
        .b_data (b_data)
    );

    mm_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .a_data (a_data),
        .b_data (b_data),
        .result (result),
        .adv    (adv),
        .done   (done)
    );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for matrix_multiply: element loads, computes and register settings.
module tb;
    import mm_pkg::*;

    localparam logic [OP_W-1:0]      OP_NONE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic signed [ELEM_W-1:0] MIN_Q = 16'sh8000;
    localparam logic signed [ELEM_W-1:0] MAX_Q = 16'sh7fff;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [ELEM_W-1:0] value;
    } mm_word_t;

    typedef struct {
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [SUM_W-1:0]  sum;
        logic                     last;
    } c_elem_t;

    logic clk;
    logic rst_n;

    mm_in_if  item_bus();
    mm_out_if result_bus();
    mm_cfg_if cfg_bus();

    matrix_multiply dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .cfg    (cfg_bus),
        .result (result_bus)
    );

    mm_word_t word_queue[$];
    c_elem_t  c_expect[$];
    mm_word_t cur_word;

    logic signed [ELEM_W-1:0] a_elems [DEPTH];
    logic signed [ELEM_W-1:0] b_elems [DEPTH];
    logic [CFG_W-1:0] rows_cfg = 4'd8;
    logic [CFG_W-1:0] inner_cfg = 4'd8;
    logic [CFG_W-1:0] cols_cfg = 4'd8;

    bit a_written [DEPTH];
    bit b_written [DEPTH];
    int gen_r = MAX_DIM;
    int gen_k = MAX_DIM;
    int gen_c = MAX_DIM;
    int words_queued = 0;

    int words_in = 0;
    int computes = 0;
    int c_checked = 0;
    int cfg_writes = 0;
    int errors = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_mode = 0;
    int stall_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("tb: done, errors");
        $finish;
    end

    function automatic int dim_eff(input logic [CFG_W-1:0] d);
        return (d > MAX_DIM) ? MAX_DIM : int'(d);
    endfunction

    task automatic multiply_word(input mm_word_t w);
        int nr;
        int nk;
        int nc;
        int n;
        logic signed [SUM_W-1:0]  acc;
        logic signed [ELEM_W-1:0] x;
        logic signed [ELEM_W-1:0] y;
        c_elem_t e;
        if (w.op == OP_WRITE_A)
        begin
            a_elems[int'(w.row) * MAX_DIM + int'(w.col)] = w.value;
        end
        else if (w.op == OP_WRITE_B)
        begin
            b_elems[int'(w.row) * MAX_DIM + int'(w.col)] = w.value;
        end
        else if (w.op == OP_COMPUTE)
        begin
            computes++;
            nr = dim_eff(rows_cfg);
            nk = dim_eff(inner_cfg);
            nc = dim_eff(cols_cfg);
            n = 0;
            for (int i = 0; i < nr; i++)
            begin
                for (int j = 0; j < nc; j++)
                begin
                    acc = '0;
                    for (int k = 0; k < nk; k++)
                    begin
                        x = a_elems[i * MAX_DIM + k];
                        y = b_elems[k * MAX_DIM + j];
                        acc = acc + x * y;
                    end
                    n++;
                    e.row = IDX_W'(i);
                    e.col = IDX_W'(j);
                    e.sum = acc;
                    e.last = (n == nr * nc);
                    c_expect.push_back(e);
                end
            end
        end
    endtask

    // Input driver: bursts of random length separated by random gaps.
    always @(posedge clk)
    begin : item_driver
        if (rst_n)
        begin
            if (item_bus.valid && item_bus.ready)
            begin
                multiply_word(cur_word);
                words_in++;
            end
            if (!item_bus.valid || item_bus.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_bus.valid <= 1'b0;
                end
                else if (word_queue.size() > 0)
                begin
                    cur_word = word_queue.pop_front();
                    item_bus.valid         <= 1'b1;
                    item_bus.operation     <= cur_word.op;
                    item_bus.row_index     <= cur_word.row;
                    item_bus.col_index     <= cur_word.col;
                    item_bus.element_value <= cur_word.value;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    item_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor, register write tracking and receiver stall pattern.
    always @(posedge clk)
    begin : result_monitor
        c_elem_t e;
        if (rst_n)
        begin
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                cfg_writes++;
                case (cfg_bus.index)
                    REG_ROWS_A:    rows_cfg = cfg_bus.data;
                    REG_INNER_DIM: inner_cfg = cfg_bus.data;
                    REG_COLS_B:    cols_cfg = cfg_bus.data;
                    default:       ;
                endcase
            end
            if (result_bus.valid && result_bus.ready)
            begin
                if (c_expect.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("tb: unexpected C word row %0d col %0d sum %0d last %0d",
                                 result_bus.out_row, result_bus.out_col,
                                 result_bus.product_value, result_bus.last);
                    end
                end
                else
                begin
                    e = c_expect.pop_front();
                    c_checked++;
                    if (result_bus.out_row !== e.row || result_bus.out_col !== e.col ||
                        result_bus.product_value !== e.sum || result_bus.last !== e.last)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("tb: C word mismatch: expected row %0d col %0d sum %0d last %0d",
                                     e.row, e.col, e.sum, e.last);
                            $display("tb:                  actual   row %0d col %0d sum %0d last %0d",
                                     result_bus.out_row, result_bus.out_col,
                                     result_bus.product_value, result_bus.last);
                        end
                    end
                end
            end
            if (stall_cycles == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                stall_cycles = $urandom_range(20, 120);
            end
            stall_cycles--;
            case (stall_mode)
                0:       result_bus.ready <= 1'b1;
                1:       result_bus.ready <= $urandom_range(0, 1);
                default: result_bus.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    function automatic logic signed [ELEM_W-1:0] pick_value();
        logic signed [ELEM_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = MIN_Q;
            1:       v = MAX_Q;
            2:       v = '0;
            3:       v = '1;
            default: v = ELEM_W'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim();
        int r;
        logic [CFG_W-1:0] d;
        r = $urandom_range(0, 19);
        if (r == 0)
        begin
            d = '0;
        end
        else if (r <= 2)
        begin
            d = CFG_W'(MAX_DIM);
        end
        else if (r == 3)
        begin
            d = CFG_W'($urandom_range(MAX_DIM + 1, 15));
        end
        else
        begin
            d = CFG_W'($urandom_range(1, 4));
        end
        return d;
    endfunction

    task automatic push_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col, input logic signed [ELEM_W-1:0] value);
        mm_word_t w;
        w.op = op;
        w.row = row;
        w.col = col;
        w.value = value;
        word_queue.push_back(w);
        if (op == OP_WRITE_A)
        begin
            a_written[int'(row) * MAX_DIM + int'(col)] = 1'b1;
        end
        else if (op == OP_WRITE_B)
        begin
            b_written[int'(row) * MAX_DIM + int'(col)] = 1'b1;
        end
        if (op != OP_NONE)
        begin
            words_queued++;
        end
    endtask

    task automatic push_write(input logic [OP_W-1:0] op);
        int rmax;
        int cmax;
        rmax = (op == OP_WRITE_A) ? gen_r : gen_k;
        cmax = (op == OP_WRITE_A) ? gen_k : gen_c;
        if ($urandom_range(0, 3) == 0 || rmax == 0 || cmax == 0)
        begin
            rmax = MAX_DIM;
            cmax = MAX_DIM;
        end
        push_word(op, IDX_W'($urandom_range(0, rmax - 1)), IDX_W'($urandom_range(0, cmax - 1)),
                  pick_value());
    endtask

    // Every entry that the compute will read is loaded first.
    task automatic push_compute();
        if (gen_r > 0 && gen_c > 0)
        begin
            for (int i = 0; i < gen_r; i++)
            begin
                for (int k = 0; k < gen_k; k++)
                begin
                    if (!a_written[i * MAX_DIM + k])
                    begin
                        push_word(OP_WRITE_A, IDX_W'(i), IDX_W'(k), pick_value());
                    end
                end
            end
            for (int k = 0; k < gen_k; k++)
            begin
                for (int j = 0; j < gen_c; j++)
                begin
                    if (!b_written[k * MAX_DIM + j])
                    begin
                        push_word(OP_WRITE_B, IDX_W'(k), IDX_W'(j), pick_value());
                    end
                end
            end
        end
        push_word(OP_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (word_queue.size() != 0 || item_bus.valid || c_expect.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic set_dims(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] k,
                            input logic [CFG_W-1:0] c);
        wait_idle();
        cfg_write(REG_ROWS_A, r);
        cfg_write(REG_INNER_DIM, k);
        cfg_write(REG_COLS_B, c);
        gen_r = dim_eff(r);
        gen_k = dim_eff(k);
        gen_c = dim_eff(c);
    endtask

    initial
    begin : stimulus
        int n_ops;
        int sel;
        int directed_words;
        item_bus.valid         = 1'b0;
        item_bus.operation     = '0;
        item_bus.row_index     = '0;
        item_bus.col_index     = '0;
        item_bus.element_value = '0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.index          = '0;
        cfg_bus.data           = '0;
        result_bus.ready       = 1'b0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_dims(4'd2, 4'd2, 4'd2);
        push_word(OP_WRITE_A, 3'd0, 3'd0, MIN_Q);
        push_word(OP_WRITE_A, 3'd0, 3'd1, MAX_Q);
        push_word(OP_WRITE_A, 3'd1, 3'd0, -16'sd1);
        push_word(OP_WRITE_A, 3'd1, 3'd1, '0);
        push_word(OP_WRITE_B, 3'd0, 3'd0, MIN_Q);
        push_word(OP_WRITE_B, 3'd0, 3'd1, MAX_Q);
        push_word(OP_WRITE_B, 3'd1, 3'd0, MAX_Q);
        push_word(OP_WRITE_B, 3'd1, 3'd1, MIN_Q);
        push_word(OP_NONE, 3'd7, 3'd7, MAX_Q);
        push_compute();
        // Writes outside the configured shape still land in the store.
        push_word(OP_WRITE_A, 3'd7, 3'd7, MAX_Q);
        push_word(OP_WRITE_B, 3'd7, 3'd0, MIN_Q);
        set_dims(4'd1, 4'd1, 4'd1);
        push_compute();
        set_dims(4'd0, 4'd3, 4'd2);
        push_compute();
        set_dims(4'd2, 4'd0, 4'd2);
        push_compute();
        set_dims(4'd3, 4'd2, 4'd0);
        push_compute();
        wait_idle();
        cfg_write(REG_SPARE, 4'hf);
        set_dims(4'd15, 4'd1, 4'd1);
        push_compute();
        directed_words = words_queued;

        while (words_queued - directed_words < 150)
        begin
            set_dims(pick_dim(), pick_dim(), pick_dim());
            n_ops = $urandom_range(6, 20);
            repeat (n_ops)
            begin
                sel = $urandom_range(0, 15);
                if (sel < 2)
                begin
                    push_compute();
                end
                else if (sel == 2)
                begin
                    push_word(OP_NONE, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
                end
                else if (sel < 9)
                begin
                    push_write(OP_WRITE_A);
                end
                else
                begin
                    push_write(OP_WRITE_B);
                end
            end
            push_compute();
        end

        wait_idle();
        repeat (20) @(negedge clk);
        $display("tb: %0d input words accepted, %0d computes, %0d register writes",
                 words_in, computes, cfg_writes);
        $display("tb: %0d C words checked, %0d mismatches", c_checked, errors);
        if (errors == 0 && c_expect.size() == 0)
        begin
            $display("tb: done, clean");
        end
        else
        begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
